FILE: rtl/scp_pkg.sv
// Shared constants and transaction types for the sine and cosine polynomial core.
// Holds the fixed-point angle constants, the polynomial coefficients and the stage payloads.
// No dependencies.
package scp_pkg;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;

    // Width of the angle magnitude moved to 32 fractional bits, and the number of
    // subtract steps needed to reduce it below two pi (two pi exceeds 2^34).
    localparam int SHIFT_W   = 64 - ANGLE_FRAC_BITS;
    localparam int RED_STEPS = SHIFT_W - 34;

    localparam int RED_W  = 35;
    localparam int FOLD_W = 33;
    localparam int X_W    = 32;
    localparam int MAG_W  = 33;
    localparam int SUM_W  = 35;
    localparam int PROD_W = 65;

    localparam logic [RED_W-1:0] Q_QUART_PI = 35'h0C90FDAA2;
    localparam logic [RED_W-1:0] Q_HALF_PI  = 35'h1921FB544;
    localparam logic [RED_W-1:0] Q_PI       = 35'h3243F6A89;
    localparam logic [RED_W-1:0] Q_3HALF_PI = 35'h4B65F1FCD;
    localparam logic [RED_W-1:0] Q_TWO_PI   = 35'h6487ED511;

    localparam logic [MAG_W-1:0] S7_MAG = 33'h0000CC600;
    localparam logic [MAG_W-1:0] C6_MAG = 33'h000591600;

    localparam logic signed [SUM_W-1:0] S5_C  = 35'sh002220B00;
    localparam logic signed [SUM_W-1:0] S3_C  = -35'sh02AAAA800;
    localparam logic signed [SUM_W-1:0] C4_C  = 35'sh00AA9F600;
    localparam logic signed [SUM_W-1:0] C2_C  = -35'sh07FFFED00;
    localparam logic signed [SUM_W-1:0] ONE_C = 35'sh100000000;

    typedef struct packed {
        logic           sel_cos;
        logic           neg;
        logic [X_W-1:0] x;
    } t_fold;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_poly;

endpackage

FILE: rtl/scp_reduce.sv
// Angle reduction pipeline: magnitude, modulo two pi, quadrant fold and octant complement.
// Produces the first-quadrant argument, the polynomial choice and the result sign.
// Depends on scp_pkg.
module scp_reduce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output scp_pkg::t_fold     o_data
);
    import scp_pkg::*;

    localparam int NS      = RED_STEPS + 4;
    localparam int ST_QUAD = RED_STEPS + 1;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic is_cos;
        logic neg;
    } t_ctl;

    logic [NS:0]   en;
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;

    logic [31:0]        angle_u;
    logic [31:0]        mag_in;
    logic [SHIFT_W-1:0] r_rx [RED_STEPS+1];
    t_ctl               r_ctl [RED_STEPS+1];

    logic [RED_W-1:0]  red_x;
    t_ctl              red_ctl;
    t_quad             quad;
    logic              quad_neg;
    logic [RED_W-1:0]  r_qx;
    t_quad             r_quad;
    t_ctl              r_qctl;

    logic [RED_W-1:0]  fold_x;
    logic [FOLD_W-1:0] r_fx;
    t_ctl              r_fctl;

    logic              use_own;
    logic [RED_W-1:0]  cmpl_x;
    t_fold             r_out;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign angle_u = i_angle;
    assign mag_in  = angle_u[31] ? (32'd0 - angle_u) : angle_u;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rx[0]  <= {mag_in, {(SHIFT_W-32){1'b0}}};
            r_ctl[0] <= '{is_cos: i_kind, neg: !i_kind && angle_u[31]};
        end
        for (int k = 0; k < RED_STEPS; k++) begin
            if (en[k+1]) begin
                if (r_rx[k] >= (SHIFT_W'(Q_TWO_PI) << (RED_STEPS - 1 - k))) begin
                    r_rx[k+1] <= r_rx[k] - (SHIFT_W'(Q_TWO_PI) << (RED_STEPS - 1 - k));
                end else begin
                    r_rx[k+1] <= r_rx[k];
                end
                r_ctl[k+1] <= r_ctl[k];
            end
        end
    end

    assign red_x   = r_rx[RED_STEPS][RED_W-1:0];
    assign red_ctl = r_ctl[RED_STEPS];

    always_comb begin
        if (red_x < Q_HALF_PI) begin
            quad = QUAD_0;
        end else if (red_x < Q_PI) begin
            quad = QUAD_1;
        end else if (red_x < Q_3HALF_PI) begin
            quad = QUAD_2;
        end else begin
            quad = QUAD_3;
        end
        unique case (quad)
            QUAD_0:  quad_neg = red_ctl.neg;
            QUAD_1:  quad_neg = red_ctl.neg ^ red_ctl.is_cos;
            QUAD_2:  quad_neg = !red_ctl.neg;
            QUAD_3:  quad_neg = red_ctl.neg ^ !red_ctl.is_cos;
            default: quad_neg = red_ctl.neg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_QUAD]) begin
            r_qx   <= red_x;
            r_quad <= quad;
            r_qctl <= '{is_cos: red_ctl.is_cos, neg: quad_neg};
        end
    end

    always_comb begin
        unique case (r_quad)
            QUAD_0:  fold_x = r_qx;
            QUAD_1:  fold_x = Q_PI - r_qx;
            QUAD_2:  fold_x = r_qx - Q_PI;
            QUAD_3:  fold_x = Q_TWO_PI - r_qx;
            default: fold_x = r_qx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_QUAD+1]) begin
            r_fx   <= fold_x[FOLD_W-1:0];
            r_fctl <= r_qctl;
        end
    end

    // From pi/4 up the other function is taken at pi/2 - x, which stops at zero.
    always_comb begin
        use_own = RED_W'(r_fx) < Q_QUART_PI;
        if (use_own) begin
            cmpl_x = RED_W'(r_fx);
        end else if (RED_W'(r_fx) >= Q_HALF_PI) begin
            cmpl_x = '0;
        end else begin
            cmpl_x = Q_HALF_PI - RED_W'(r_fx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_QUAD+2]) begin
            r_out <= '{sel_cos: r_fctl.is_cos == use_own,
                       neg:     r_fctl.neg,
                       x:       cmpl_x[X_W-1:0]};
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_out;

endmodule

FILE: rtl/scp_poly.sv
// Horner evaluation pipeline for the sine and cosine polynomials in signed magnitude.
// Each step has a multiply stage and a round-and-add stage.
// Depends on scp_pkg.
module scp_poly (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scp_pkg::t_fold i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output scp_pkg::t_poly o_data
);
    import scp_pkg::*;

    localparam int PS = 10;

    typedef struct packed {
        logic              sel_cos;
        logic              neg;
        logic [X_W-1:0]    x;
        logic [X_W-1:0]    x2;
        logic              t_neg;
        logic [MAG_W-1:0]  t_mag;
        logic [PROD_W-1:0] p;
    } t_hstage;

    logic [PS:0]   en;
    logic [PS-1:0] r_v;
    logic [PS-1:0] n_v;
    t_hstage       r_s [PS];
    t_hstage       n_s [PS];

    function automatic logic [PROD_W-1:0] round_q32(input logic [PROD_W-1:0] p);
        return p + (PROD_W'(1) << 31);
    endfunction

    function automatic logic signed [SUM_W-1:0] horner_coef(input int idx,
                                                           input logic sel_cos);
        logic signed [SUM_W-1:0] c;
        case (idx)
            0:       c = sel_cos ? C4_C : S5_C;
            1:       c = sel_cos ? C2_C : S3_C;
            default: c = ONE_C;
        endcase
        return c;
    endfunction

    always_comb begin
        en[PS] = i_ready;
        for (int k = PS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[PS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < PS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_comb begin
        logic [PROD_W-1:0]       rnd;
        logic signed [SUM_W-1:0] ps;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] ns;
        n_s[0]         = '0;
        n_s[0].sel_cos = i_data.sel_cos;
        n_s[0].neg     = i_data.neg;
        n_s[0].x       = i_data.x;
        n_s[0].p       = PROD_W'(i_data.x) * PROD_W'(i_data.x);
        for (int k = 1; k < PS; k++) begin
            n_s[k] = r_s[k-1];
            rnd    = round_q32(r_s[k-1].p);
            ps     = '0;
            c      = '0;
            s      = '0;
            ns     = '0;
            if (k == 1) begin
                n_s[k].x2    = rnd[32 +: X_W];
                n_s[k].t_neg = 1'b1;
                n_s[k].t_mag = r_s[k-1].sel_cos ? C6_MAG : S7_MAG;
            end else if (k == PS - 1) begin
                n_s[k].t_mag = r_s[k-1].sel_cos ? r_s[k-1].t_mag : rnd[32 +: MAG_W];
                n_s[k].neg   = r_s[k-1].neg ^ r_s[k-1].t_neg;
            end else if (k % 2 == 0) begin
                if (k == PS - 2) begin
                    n_s[k].p = PROD_W'(r_s[k-1].t_mag) * PROD_W'(r_s[k-1].x);
                end else begin
                    n_s[k].p = PROD_W'(r_s[k-1].t_mag) * PROD_W'(r_s[k-1].x2);
                end
            end else begin
                ps = {{(SUM_W-MAG_W){1'b0}}, rnd[32 +: MAG_W]};
                c  = horner_coef((k - 3) / 2, r_s[k-1].sel_cos);
                s  = r_s[k-1].t_neg ? (c - ps) : (c + ps);
                ns = r_s[k-1].t_neg ? (ps - c) : (-c - ps);
                n_s[k].t_neg = s[SUM_W-1];
                n_s[k].t_mag = s[SUM_W-1] ? ns[MAG_W-1:0] : s[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PS; k++) begin
            if (en[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[PS-1];
    assign o_data  = '{neg: r_s[PS-1].neg, mag: r_s[PS-1].t_mag};

endmodule

FILE: rtl/scp_round.sv
// Output pipeline: rounds the magnitude to the result format, clamps it to one
// and applies the sign. Depends on scp_pkg.
module scp_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  scp_pkg::t_poly     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value
);
    import scp_pkg::*;

    localparam int NS    = 3;
    localparam int SH    = 32 - RESULT_FRAC_BITS;
    localparam int RND_W = MAG_W + 1;
    localparam int LIM_W = RESULT_FRAC_BITS + 1;

    localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (SH - 1);
    localparam logic [RND_W-1:0] LIM      = RND_W'(1) << RESULT_FRAC_BITS;

    logic [NS:0]   en;
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;

    logic [RND_W-1:0] rnd_sum;
    logic [RND_W-1:0] r_m0;
    logic             r_neg0;
    logic [LIM_W-1:0] r_m1;
    logic             r_neg1;
    logic [31:0]      m_ext;
    logic [31:0]      r_value;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign rnd_sum = RND_W'(i_data.mag) + HALF_LSB;
    assign m_ext   = 32'(r_m1);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_m0   <= rnd_sum >> SH;
            r_neg0 <= i_data.neg;
        end
        if (en[1]) begin
            r_m1   <= (r_m0 > LIM) ? LIM[LIM_W-1:0] : r_m0[LIM_W-1:0];
            r_neg1 <= r_neg0;
        end
        if (en[2]) begin
            r_value <= r_neg1 ? (32'd0 - m_ext) : m_ext;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_value = r_value;

endmodule

FILE: rtl/sine_cosine_polynomial_core.sv
// Top level of the sine and cosine polynomial core: reduction, polynomial and output pipelines.
// Depends on scp_pkg, scp_reduce, scp_poly and scp_round.
//
//   Channel   Handshake           Payload
//   input     i_valid / o_ready   i_kind (0 sine, 1 cosine), i_angle (Q8.24 radians)
//   output    o_valid / i_ready   o_value (Q2.30, clamped to plus or minus one)
//
// One transaction is accepted per cycle unless an output stall has backed up to the input
// stage. The pipeline has one subtract stage per quotient bit of the modulo two pi reduction,
// four folding stages, ten Horner stages and three output stages.
// Reset clears every valid bit; data registers are not reset.
// A stall on the output holds the full stages while empty stages ahead keep filling.
module sine_cosine_polynomial_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value
);
    import scp_pkg::*;

    logic  fold_valid;
    logic  fold_ready;
    t_fold fold_data;
    logic  poly_valid;
    logic  poly_ready;
    t_poly poly_data;

    scp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .i_angle (i_angle),
        .o_valid (fold_valid),
        .i_ready (fold_ready),
        .o_data  (fold_data)
    );

    scp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_valid),
        .o_ready (fold_ready),
        .i_data  (fold_data),
        .o_valid (poly_valid),
        .i_ready (poly_ready),
        .o_data  (poly_data)
    );

    scp_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (poly_valid),
        .o_ready (poly_ready),
        .i_data  (poly_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_value (o_value)
    );

endmodule

FILE: dv/sincos_checker.sv
// Checker for the sine and cosine polynomial core: watches both channels and scores results.
// Predicts each accepted angle in fixed point and compares results in order.
// Depends on scp_pkg for the angle constants and the fraction widths.
module sincos_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_angle,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_value,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int ANGLE_SHIFT  = 32 - scp_pkg::ANGLE_FRAC_BITS;
    localparam int RESULT_SHIFT = 32 - scp_pkg::RESULT_FRAC_BITS;

    localparam logic [63:0] QUARTER_PI    = 64'(scp_pkg::Q_QUART_PI);
    localparam logic [63:0] HALF_PI       = 64'(scp_pkg::Q_HALF_PI);
    localparam logic [63:0] PI            = 64'(scp_pkg::Q_PI);
    localparam logic [63:0] THREE_HALF_PI = 64'(scp_pkg::Q_3HALF_PI);
    localparam logic [63:0] TWO_PI        = 64'(scp_pkg::Q_TWO_PI);
    localparam logic [63:0] RESULT_LIMIT  = 64'd1 << scp_pkg::RESULT_FRAC_BITS;

    localparam logic signed [63:0] UNIT   = 64'sh1_0000_0000;
    localparam logic signed [63:0] SIN_C3 = -64'sh2AAA_A800;
    localparam logic signed [63:0] SIN_C5 = 64'sh0222_0B00;
    localparam logic signed [63:0] SIN_C7 = -64'sh000C_C600;
    localparam logic signed [63:0] COS_C2 = -64'sh7FFF_ED00;
    localparam logic signed [63:0] COS_C4 = 64'sh0AA9_F600;
    localparam logic signed [63:0] COS_C6 = -64'sh0059_1600;

    typedef struct {
        logic        kind;
        logic [31:0] angle;
        logic [31:0] value;
    } t_sincos_txn;

    t_sincos_txn expected_values[$];
    int          error_count;
    int          checked_count;
    int          pending_count;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_checked = checked_count;

    function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                     input logic [63:0] b);
        logic [63:0]  ma;
        logic [127:0] p;
        ma = a[63] ? 64'(-a) : a;
        p  = {64'd0, ma} * {64'd0, b} + 128'h8000_0000;
        p  = p >> 32;
        return a[63] ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic logic [63:0] round_square(input logic [63:0] x);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, x} + 128'h8000_0000;
        return p[95:32];
    endfunction

    function automatic logic signed [63:0] sin_series(input logic [63:0] x);
        logic [63:0]        x2;
        logic signed [63:0] t;
        x2 = round_square(x);
        t  = round_mul(SIN_C7, x2) + SIN_C5;
        t  = round_mul(t, x2) + SIN_C3;
        t  = round_mul(t, x2) + UNIT;
        return round_mul(t, x);
    endfunction

    function automatic logic signed [63:0] cos_series(input logic [63:0] x);
        logic [63:0]        x2;
        logic signed [63:0] t;
        x2 = round_square(x);
        t  = round_mul(COS_C6, x2) + COS_C4;
        t  = round_mul(t, x2) + COS_C2;
        return round_mul(t, x2) + UNIT;
    endfunction

    function automatic logic [31:0] predict_sincos(input logic sel_cos,
                                                   input logic [31:0] angle);
        logic               neg;
        logic               use_own;
        logic [63:0]        mag;
        logic [63:0]        x;
        logic [63:0]        m;
        logic signed [63:0] y;
        mag = angle[31] ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        x   = (mag << ANGLE_SHIFT) % TWO_PI;
        neg = sel_cos ? 1'b0 : angle[31];
        if (x < HALF_PI) begin
        end else if (x < PI) begin
            x = PI - x;
            if (sel_cos) neg = !neg;
        end else if (x < THREE_HALF_PI) begin
            x   = x - PI;
            neg = !neg;
        end else begin
            x = TWO_PI - x;
            if (!sel_cos) neg = !neg;
        end
        use_own = x < QUARTER_PI;
        if (!use_own) x = (x >= HALF_PI) ? 64'd0 : HALF_PI - x;
        y = (sel_cos == use_own) ? cos_series(x) : sin_series(x);
        if (y < 0) begin
            neg = !neg;
            m   = 64'(-y);
        end else begin
            m = y;
        end
        m = (m + (64'd1 << (RESULT_SHIFT - 1))) >> RESULT_SHIFT;
        if (m > RESULT_LIMIT) m = RESULT_LIMIT;
        if (neg) m = -m;
        return m[31:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_sincos_txn head;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_values.push_back('{i_kind, i_angle, predict_sincos(i_kind, i_angle)});
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_values.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result transaction: expected none, got %h",
                             $time, i_value);
                end else begin
                    head = expected_values.pop_front();
                    checked_count++;
                    if (i_value !== head.value) begin
                        error_count++;
                        $display("%0t: value mismatch (kind %0d, angle %h): expected %h, got %h",
                                 $time, head.kind, head.angle, head.value, i_value);
                    end
                end
            end
            pending_count <= expected_values.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the sine and cosine polynomial core testbench: clock, reset, stimulus and verdict.
// Drives directed and random angles under idle, stall and back-pressure phases.
// Depends on scp_pkg, sine_cosine_polynomial_core and sincos_checker.
module testbench;

    localparam logic KIND_SINE   = 1'b0;
    localparam logic KIND_COSINE = 1'b1;

    localparam int ANGLE_SHIFT = 32 - scp_pkg::ANGLE_FRAC_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_GAP     = 64;

    localparam logic [31:0] OCTANT_STEP = 32'(scp_pkg::Q_QUART_PI >> ANGLE_SHIFT);
    localparam logic [31:0] CORNERS [12] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'(scp_pkg::Q_QUART_PI >> ANGLE_SHIFT),
        32'(scp_pkg::Q_HALF_PI >> ANGLE_SHIFT),
        32'(scp_pkg::Q_PI >> ANGLE_SHIFT),
        32'(scp_pkg::Q_3HALF_PI >> ANGLE_SHIFT),
        32'(scp_pkg::Q_TWO_PI >> ANGLE_SHIFT),
        -32'(scp_pkg::Q_HALF_PI >> ANGLE_SHIFT),
        -32'(scp_pkg::Q_PI >> ANGLE_SHIFT)
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               i_kind;
    logic signed [31:0] i_angle;
    logic               i_ready;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_value;

    int errors;
    int pending;
    int checked;
    int sin_sent       = 0;
    int cos_sent       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    sine_cosine_polynomial_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (i_kind),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_value (o_value)
    );

    sincos_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_kind      (i_kind),
        .i_angle     (i_angle),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_value     (o_value),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // The receiver stalls at random, and once on request holds off for a long stretch.
    initial begin : receiver
        int n;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] pick_angle();
        int unsigned sel;
        logic [31:0] a;
        sel = $urandom_range(99);
        if (sel < 40) begin
            a = $urandom;
        end else if (sel < 65) begin
            a = $urandom_range(32'h0800_0000);
        end else if (sel < 90) begin
            a = $urandom_range(160) * OCTANT_STEP + $urandom_range(8) - 4;
        end else if (sel < 95) begin
            a = $urandom_range(511) - 256;
        end else if ($urandom_range(1) == 1) begin
            a = 32'h8000_0000 + $urandom_range(3);
        end else begin
            a = 32'h7FFF_FFFF - $urandom_range(3);
        end
        if (sel >= 40 && sel < 90 && $urandom_range(1) == 1) a = -a;
        return a;
    endfunction

    task automatic push_angle(input logic kind, input logic [31:0] angle);
        int gap;
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_angle <= angle;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind == KIND_COSINE) cos_sent++;
        else sin_sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) push_angle(1'($urandom_range(1)), pick_angle());
    endtask

    initial begin : stimulus
        int j;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind  <= KIND_SINE;
        i_angle <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (j = 0; j < 12; j++) begin
            push_angle(KIND_SINE, CORNERS[j]);
            push_angle(KIND_COSINE, CORNERS[j]);
        end

        run_phase(300, 0, 0);
        run_phase(300, 84, 0);
        run_phase(300, 0, 84);
        run_phase(350, 14, 14);
        hold_req = 1'b1;
        run_phase(300, 0, 0);
        run_phase(280, 14, 14);

        i_valid        <= 1'b0;
        recv_stall_pct  = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d sine and %0d cosine transactions, %0d results checked,",
                 sin_sent, cos_sent, checked);
        $display("across free-running, idle, stall and long back-pressure phases.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sine_cosine_polynomial_core.f
rtl/scp_pkg.sv
rtl/scp_reduce.sv
rtl/scp_poly.sv
rtl/scp_round.sv
rtl/sine_cosine_polynomial_core.sv
dv/sincos_checker.sv
dv/testbench.sv
